/* rtl/cbk_pkg.sv */
package cbk_pkg;

   localparam int DOUBLE_ROUNDS = 10;

   // half of four quarter rounds per ring stage: four half steps per double round
   localparam int STEP_TOTAL = 4 * DOUBLE_ROUNDS;
   localparam int STEP_W     = $clog2(STEP_TOTAL);
   localparam int RING_STAGES = 5;
   localparam int TAG_W      = $clog2(RING_STAGES) + 1;

   localparam int REQ_QUEUE_DEPTH = 2;
   localparam int REQ_PTR_W       = $clog2(REQ_QUEUE_DEPTH);
   localparam int REQ_CNT_W       = $clog2(REQ_QUEUE_DEPTH + 1);

   localparam int STATE_WORDS = 16;
   localparam int OUT_WORDS   = STATE_WORDS / 2;
   localparam int OUT_IDX_W   = $clog2(OUT_WORDS);

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   typedef enum logic [2:0] {
      CSR_KEY_PART_0 = 3'd0,
      CSR_KEY_PART_1 = 3'd1,
      CSR_KEY_PART_2 = 3'd2,
      CSR_KEY_PART_3 = 3'd3,
      CSR_NONCE_LOW  = 3'd4,
      CSR_NONCE_HIGH = 3'd5
   } csr_index_type;

   typedef logic [31:0] word_type;
   typedef logic [STATE_WORDS-1:0][31:0] state_type;

   typedef struct packed {
      logic [3:0][63:0] key;
      logic [63:0]      nonce_low;
      logic [31:0]      nonce_high;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              done;
      logic [STEP_W-1:0] step;
      logic [TAG_W-1:0]  tag;
      logic [31:0]       counter;
      state_type         state;
   } slot_type;

   // finished block leaving the round ring
   typedef struct packed {
      logic      valid;
      logic [31:0] counter;
      state_type state;
   } done_type;

   function automatic state_type build_state(cfg_type cfg, logic [31:0] counter);
      state_type s;
      s[0] = SIGMA_0;
      s[1] = SIGMA_1;
      s[2] = SIGMA_2;
      s[3] = SIGMA_3;
      for (int i = 0; i < 4; i++) begin
         s[4 + 2 * i] = cfg.key[i][31:0];
         s[5 + 2 * i] = cfg.key[i][63:32];
      end
      s[12] = counter;
      s[13] = cfg.nonce_low[31:0];
      s[14] = cfg.nonce_low[63:32];
      s[15] = cfg.nonce_high;
      return s;
   endfunction

   function automatic word_type rotl(word_type x, int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // four quarter rounds side by side, first or second half of each;
   // diag selects the diagonal pattern over the columns
   function automatic state_type half_step(state_type s, logic diag, logic second);
      state_type r;
      word_type  a;
      word_type  b;
      word_type  c;
      word_type  d;
      logic [3:0] ia;
      logic [3:0] ib;
      logic [3:0] ic;
      logic [3:0] id;
      r = s;
      for (int q = 0; q < 4; q++) begin
         ia = 4'(q);
         ib = diag ? 4'(4 + ((q + 1) & 3))  : 4'(4 + q);
         ic = diag ? 4'(8 + ((q + 2) & 3))  : 4'(8 + q);
         id = diag ? 4'(12 + ((q + 3) & 3)) : 4'(12 + q);
         a = s[ia];
         b = s[ib];
         c = s[ic];
         d = s[id];
         a = a + b;
         d = second ? rotl(d ^ a, 8) : rotl(d ^ a, 16);
         c = c + d;
         b = second ? rotl(b ^ c, 7) : rotl(b ^ c, 12);
         r[ia] = a;
         r[ib] = b;
         r[ic] = c;
         r[id] = d;
      end
      return r;
   endfunction

endpackage

/* rtl/cbk_req_queue.sv */
module cbk_req_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_block_counter,
   output logic        head_valid,
   output logic [31:0] head_counter,
   input  logic        head_pop
);

   logic [cbk_pkg::REQ_QUEUE_DEPTH-1:0][31:0] entry_ff;
   logic [cbk_pkg::REQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cbk_pkg::REQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cbk_pkg::REQ_CNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign req_stall    = (count_ff == cbk_pkg::REQ_CNT_W'(cbk_pkg::REQ_QUEUE_DEPTH));
   assign head_valid   = (count_ff != '0);
   assign head_counter = entry_ff[rd_ptr_ff];
   assign push = req_valid && !req_stall;
   assign pop  = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cbk_pkg::REQ_PTR_W'(cbk_pkg::REQ_QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cbk_pkg::REQ_PTR_W'(cbk_pkg::REQ_QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_block_counter;
      end
   end

endmodule

/* rtl/cbk_round_ring.sv */
module cbk_round_ring (
   input  logic                clock,
   input  logic                reset,
   input  cbk_pkg::cfg_type    cfg,
   input  logic                head_valid,
   input  logic [31:0]         head_counter,
   output logic                head_pop,
   input  logic                out_ready,
   output cbk_pkg::done_type   done_out
);

   localparam int LAST = cbk_pkg::RING_STAGES - 1;

   cbk_pkg::slot_type [cbk_pkg::RING_STAGES-1:0] ring_ff, ring_in;
   logic [cbk_pkg::TAG_W-1:0] entry_tag_ff, entry_tag_in;
   logic [cbk_pkg::TAG_W-1:0] exit_tag_ff, exit_tag_in;
   logic exiting;

   function automatic cbk_pkg::slot_type advance(cbk_pkg::slot_type s);
      cbk_pkg::slot_type r;
      r = s;
      if (s.valid && !s.done) begin
         r.state = cbk_pkg::half_step(s.state, s.step[1], s.step[0]);
         if (s.step == cbk_pkg::STEP_W'(cbk_pkg::STEP_TOTAL - 1)) begin
            r.done = 1'b1;
         end else begin
            r.step = s.step + 1'b1;
         end
      end
      return r;
   endfunction

   // blocks leave strictly in arrival order; a finished block that is not next
   // keeps circulating untouched
   assign exiting = ring_ff[LAST].valid && ring_ff[LAST].done &&
                    (ring_ff[LAST].tag == exit_tag_ff) && out_ready;

   assign done_out.valid   = exiting;
   assign done_out.counter = ring_ff[LAST].counter;
   assign done_out.state   = ring_ff[LAST].state;

   always_comb begin
      head_pop     = 1'b0;
      entry_tag_in = entry_tag_ff;
      exit_tag_in  = exiting ? exit_tag_ff + 1'b1 : exit_tag_ff;
      for (int i = 1; i < cbk_pkg::RING_STAGES; i++) begin
         ring_in[i] = advance(ring_ff[i-1]);
      end
      if (ring_ff[LAST].valid && !exiting) begin
         ring_in[0] = advance(ring_ff[LAST]);
      end else begin
         ring_in[0]         = ring_ff[LAST];
         ring_in[0].valid   = head_valid;
         ring_in[0].done    = 1'b0;
         ring_in[0].step    = '0;
         ring_in[0].tag     = entry_tag_ff;
         ring_in[0].counter = head_counter;
         ring_in[0].state   = cbk_pkg::build_state(cfg, head_counter);
         if (head_valid) begin
            head_pop     = 1'b1;
            entry_tag_in = entry_tag_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbk_pkg::RING_STAGES; i++) begin
            ring_ff[i].valid <= 1'b0;
         end
         entry_tag_ff <= '0;
         exit_tag_ff  <= '0;
      end else begin
         ring_ff      <= ring_in;
         entry_tag_ff <= entry_tag_in;
         exit_tag_ff  <= exit_tag_in;
      end
   end

endmodule

/* rtl/cbk_out_buffer.sv */
module cbk_out_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  cbk_pkg::cfg_type                    cfg,
   input  cbk_pkg::done_type                   done_in,
   output logic                                out_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [63:0]                         rsp_keystream_word,
   output logic [cbk_pkg::OUT_IDX_W-1:0]       rsp_word_index,
   output logic                                rsp_last_word
);

   localparam logic [cbk_pkg::OUT_IDX_W-1:0] LAST_IDX =
      cbk_pkg::OUT_IDX_W'(cbk_pkg::OUT_WORDS - 1);

   cbk_pkg::state_type block_ff, block_in;
   cbk_pkg::state_type start_state;
   logic valid_ff, valid_in;
   logic [cbk_pkg::OUT_IDX_W-1:0] idx_ff, idx_in;
   logic taken;

   assign taken     = valid_ff && !rsp_stall;
   assign out_ready = !valid_ff || (taken && (idx_ff == LAST_IDX));
   assign start_state = cbk_pkg::build_state(cfg, done_in.counter);

   assign rsp_valid          = valid_ff;
   assign rsp_keystream_word = {block_ff[{idx_ff, 1'b1}], block_ff[{idx_ff, 1'b0}]};
   assign rsp_word_index     = idx_ff;
   assign rsp_last_word      = (idx_ff == LAST_IDX);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      block_in = block_ff;
      if (taken) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            valid_in = 1'b0;
         end
      end
      if (done_in.valid) begin
         valid_in = 1'b1;
         idx_in   = '0;
         // feed-forward of the starting state
         for (int i = 0; i < cbk_pkg::STATE_WORDS; i++) begin
            block_in[i] = done_in.state[i] + start_state[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

endmodule

/* rtl/chacha20_block_keystream_unit.sv */
// ChaCha20 block keystream unit. Each request carries a 32-bit block counter;
// key and nonce come from the csr_ registers, which must be written only while
// the unit is idle; the unit itself does not enforce this. Every request yields
// eight 64-bit little-endian keystream words (word k holds bytes 8k..8k+7) with
// rsp_last_word on the eighth. A two-entry request queue feeds a ring of five
// half-round stages: a block makes 40 half steps, eight laps of the ring, then
// moves on to the exit stage. Once its first word is offered, the other seven
// follow on consecutive cycles while rsp_stall is low. Up to five blocks
// circulate at once, so new requests are taken before earlier blocks finish,
// and results leave in request order. A finished block that is not next in
// order, or that finds the result buffer still busy, goes round another lap.
module chacha20_block_keystream_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_block_counter,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_keystream_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cbk_pkg::cfg_type cfg_ff, cfg_in;
   cbk_pkg::done_type done_blk;
   logic        head_valid;
   logic [31:0] head_counter;
   logic        head_pop;
   logic        out_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cbk_pkg::CSR_KEY_PART_0: cfg_in.key[0]     = csr_wdata;
            cbk_pkg::CSR_KEY_PART_1: cfg_in.key[1]     = csr_wdata;
            cbk_pkg::CSR_KEY_PART_2: cfg_in.key[2]     = csr_wdata;
            cbk_pkg::CSR_KEY_PART_3: cfg_in.key[3]     = csr_wdata;
            cbk_pkg::CSR_NONCE_LOW:  cfg_in.nonce_low  = csr_wdata;
            cbk_pkg::CSR_NONCE_HIGH: cfg_in.nonce_high = csr_wdata[31:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbk_req_queue u_req_queue (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_block_counter (req_block_counter),
      .head_valid        (head_valid),
      .head_counter      (head_counter),
      .head_pop          (head_pop)
   );

   cbk_round_ring u_round_ring (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_counter (head_counter),
      .head_pop     (head_pop),
      .out_ready    (out_ready),
      .done_out     (done_blk)
   );

   cbk_out_buffer u_out_buffer (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .done_in            (done_blk),
      .out_ready          (out_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

endmodule

/* tb/sv/tb_chacha20_block_keystream_unit.sv */
`timescale 1ns / 100ps

module tb_chacha20_block_keystream_unit;

   localparam logic [31:0] CONST_0 = 32'h61707865;
   localparam logic [31:0] CONST_1 = 32'h3320646e;
   localparam logic [31:0] CONST_2 = 32'h79622d32;
   localparam logic [31:0] CONST_3 = 32'h6b206574;

   // indexes past the last register; writes there must have no effect
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 250;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 104;

   typedef logic [15:0][31:0] block_state_type;

   typedef struct {
      logic [63:0] data;
      logic [2:0]  pos;
      logic        last;
   } ks_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_block_counter = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_keystream_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // shadow copy of the key and nonce registers
   logic [63:0] key_shadow [4];
   logic [63:0] nonce_lo_shadow;
   logic [31:0] nonce_hi_shadow;

   logic [31:0]     pending_counters [$];
   ks_word_type     keystream_due [$];
   block_state_type blk_state;
   ks_word_type     want;

   bit calm = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int words_seen = 0;
   int mismatches = 0;

   chacha20_block_keystream_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_block_counter  (req_block_counter),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic block_state_type quarter_round(block_state_type s, int a, int b, int c,
                                                     int d);
      s[a] = s[a] + s[b];  s[d] = rol(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d];  s[b] = rol(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b];  s[d] = rol(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d];  s[b] = rol(s[b] ^ s[c], 7);
      return s;
   endfunction

   function automatic block_state_type chacha_block(logic [31:0] ctr);
      block_state_type init;
      block_state_type mix;
      init[0] = CONST_0;
      init[1] = CONST_1;
      init[2] = CONST_2;
      init[3] = CONST_3;
      for (int k = 0; k < 4; k++) begin
         init[4 + 2 * k] = key_shadow[k][31:0];
         init[5 + 2 * k] = key_shadow[k][63:32];
      end
      init[12] = ctr;
      init[13] = nonce_lo_shadow[31:0];
      init[14] = nonce_lo_shadow[63:32];
      init[15] = nonce_hi_shadow;
      mix = init;
      for (int r = 0; r < cbk_pkg::DOUBLE_ROUNDS; r++) begin
         mix = quarter_round(mix, 0, 4, 8, 12);
         mix = quarter_round(mix, 1, 5, 9, 13);
         mix = quarter_round(mix, 2, 6, 10, 14);
         mix = quarter_round(mix, 3, 7, 11, 15);
         mix = quarter_round(mix, 0, 5, 10, 15);
         mix = quarter_round(mix, 1, 6, 11, 12);
         mix = quarter_round(mix, 2, 7, 8, 13);
         mix = quarter_round(mix, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++)
         mix[i] = mix[i] + init[i];
      return mix;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            blk_state = chacha_block(req_block_counter);
            for (int k = 0; k < 8; k++)
               keystream_due.push_back('{data: {blk_state[2 * k + 1], blk_state[2 * k]},
                                         pos: 3'(k), last: (k == 7)});
         end
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_counters.size() != 0) begin
            req_block_counter <= pending_counters.pop_front();
            req_valid <= 1'b1;
            send_gap = calm ? 0 : $urandom_range(0, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // keystream monitor and output back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_seen++;
            if (keystream_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected keystream word %h index %0d last %b",
                           rsp_keystream_word, rsp_word_index, rsp_last_word);
            end else begin
               want = keystream_due.pop_front();
               if (rsp_keystream_word !== want.data || rsp_word_index !== want.pos ||
                   rsp_last_word !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("keystream mismatch: expected %h/%0d/%b got %h/%0d/%b",
                              want.data, want.pos, want.last,
                              rsp_keystream_word, rsp_word_index, rsp_last_word);
               end
            end
            stall_left = calm ? 0 : $urandom_range(0, 3);
            // long hold-off so the request side backs up
            if (words_seen == 400 || words_seen == 2000)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_put(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         cbk_pkg::CSR_KEY_PART_0: key_shadow[0] = val;
         cbk_pkg::CSR_KEY_PART_1: key_shadow[1] = val;
         cbk_pkg::CSR_KEY_PART_2: key_shadow[2] = val;
         cbk_pkg::CSR_KEY_PART_3: key_shadow[3] = val;
         cbk_pkg::CSR_NONCE_LOW:  nonce_lo_shadow = val;
         cbk_pkg::CSR_NONCE_HIGH: nonce_hi_shadow = val[31:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // wait until every request is in and every word is back, then let the unit settle
   task automatic drain();
      do @(negedge clock);
      while (pending_counters.size() != 0 || req_valid || keystream_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_reg_value();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      for (int k = 0; k < 4; k++)
         key_shadow[k] = '0;
      nonce_lo_shadow = '0;
      nonce_hi_shadow = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      drain();

      // reset configuration, counter extremes including wrap value
      pending_counters.push_back(32'h0000_0000);
      pending_counters.push_back(32'hFFFF_FFFF);
      pending_counters.push_back(32'h0000_0001);
      drain();

      // everything ones; nonce_high gets a full 64-bit write, upper half must drop
      csr_put(cbk_pkg::CSR_KEY_PART_0, '1);
      csr_put(cbk_pkg::CSR_KEY_PART_1, '1);
      csr_put(cbk_pkg::CSR_KEY_PART_2, '1);
      csr_put(cbk_pkg::CSR_KEY_PART_3, '1);
      csr_put(cbk_pkg::CSR_NONCE_LOW, '1);
      csr_put(cbk_pkg::CSR_NONCE_HIGH, '1);
      pending_counters.push_back(32'h0000_0000);
      pending_counters.push_back(32'hFFFF_FFFF);
      pending_counters.push_back(32'h8000_0000);
      pending_counters.push_back(32'h7FFF_FFFF);
      pending_counters.push_back(32'h0000_0001);
      pending_counters.push_back(32'hAAAA_AAAA);
      pending_counters.push_back(32'h5555_5555);
      drain();

      // standard known-answer key and nonce, junk above nonce_high, spare indexes
      csr_put(cbk_pkg::CSR_KEY_PART_0, 64'h0706050403020100);
      csr_put(cbk_pkg::CSR_KEY_PART_1, 64'h0f0e0d0c0b0a0908);
      csr_put(cbk_pkg::CSR_KEY_PART_2, 64'h1716151413121110);
      csr_put(cbk_pkg::CSR_KEY_PART_3, 64'h1f1e1d1c1b1a1918);
      csr_put(cbk_pkg::CSR_NONCE_LOW, 64'h4a00000009000000);
      csr_put(cbk_pkg::CSR_NONCE_HIGH, 64'hDEADBEEF_00000000);
      csr_put(CSR_SPARE_6, '1);
      csr_put(CSR_SPARE_7, {$urandom, $urandom});
      pending_counters.push_back(32'h0000_0001);
      pending_counters.push_back(32'h0000_0002);
      pending_counters.push_back(32'h0000_0000);
      pending_counters.push_back(32'hFFFF_FFFE);
      pending_counters.push_back(32'h1234_5678);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         calm = (ph == 2);
         csr_put(cbk_pkg::CSR_KEY_PART_0, pick_reg_value());
         csr_put(cbk_pkg::CSR_KEY_PART_1, pick_reg_value());
         csr_put(cbk_pkg::CSR_KEY_PART_2, pick_reg_value());
         csr_put(cbk_pkg::CSR_KEY_PART_3, pick_reg_value());
         csr_put(cbk_pkg::CSR_NONCE_LOW, pick_reg_value());
         csr_put(cbk_pkg::CSR_NONCE_HIGH, pick_reg_value());
         if ($urandom_range(0, 1) != 0)
            csr_put($urandom_range(0, 1) != 0 ? CSR_SPARE_6 : CSR_SPARE_7, pick_reg_value());
         @(negedge clock);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0:       pending_counters.push_back(32'h0000_0000);
               1:       pending_counters.push_back(32'hFFFF_FFFF);
               2:       pending_counters.push_back(32'($urandom_range(0, 15)));
               default: pending_counters.push_back($urandom);
            endcase
         end
         drain();
      end

      mismatches += keystream_due.size();
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/cbk_pkg.sv
rtl/cbk_req_queue.sv
rtl/cbk_round_ring.sv
rtl/cbk_out_buffer.sv
rtl/chacha20_block_keystream_unit.sv
tb/sv/tb_chacha20_block_keystream_unit.sv
